>>> sv/merge_sort_two_key_records_macros.svh
// Assertion macros shared by the record sorter. Each expects clk and arst_n in scope.
`ifndef MERGE_SORT_TWO_KEY_RECORDS_MACROS_SVH
`define MERGE_SORT_TWO_KEY_RECORDS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSTK_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSTK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mstk_pkg.sv
package mstk_pkg;

	localparam int unsigned DEPTH_DEF    = 1024;
	localparam int unsigned KEY_BITS_DEF = 32;
	localparam int unsigned TAG_BITS_DEF = 16;

	localparam int unsigned OP_W      = 2;
	localparam int unsigned KEY_W     = 32;
	localparam int unsigned TAG_W     = 16;
	localparam int unsigned POS_W     = 10;
	localparam int unsigned CNT_OUT_W = 11;
	localparam int unsigned STATUS_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_SORT  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Progress of one range on the frame stack.
	typedef enum logic [1:0] {
		FR_NEW   = 2'd0,
		FR_LEFT  = 2'd1,
		FR_RIGHT = 2'd2
	} stage_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] material_key;
		logic [KEY_W-1:0] mesh_key;
		logic [TAG_W-1:0] item_tag;
		logic [POS_W-1:0] position;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0]     out_material_key;
		logic [KEY_W-1:0]     out_mesh_key;
		logic [TAG_W-1:0]     out_tag;
		logic [CNT_OUT_W-1:0] item_count;
		logic [STATUS_W-1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic push;
		logic clear;
		logic rsp_load;
		logic frame_init;
		logic split_left;
		logic split_right;
		logic pop;
		logic copy_init;
		logic copy_wr;
		logic merge_init;
		logic merge_wr;
	} dp_cmd_t;

	typedef struct packed {
		op_t    op;
		logic   trivial;
		logic   stk_empty;
		stage_t stage;
		logic   leaf;
		logic   last;
	} dp_stat_t;

endpackage

>>> sv/mstk_chan_if.sv
interface mstk_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

>>> sv/mstk_ram.sv
module mstk_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic [WIDTH-1:0]         rd_data_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

>>> sv/mstk_dp.sv
module mstk_dp #(
	parameter int unsigned DEPTH    = mstk_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS = mstk_pkg::KEY_BITS_DEF,
	parameter int unsigned TAG_BITS = mstk_pkg::TAG_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mstk_pkg::cmd_t     in_word,
	output mstk_pkg::rsp_t     out_word,
	input  mstk_pkg::dp_cmd_t  ctl,
	output mstk_pkg::dp_stat_t stat
);

	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned KW    = 2 * KEY_BITS;
	localparam int unsigned RW    = KW + TAG_BITS;
	localparam int unsigned SD    = AW + 1;
	localparam int unsigned SPW   = $clog2(SD);
	localparam int unsigned SPC_W = $clog2(SD + 1);
	localparam int unsigned CMP_W = (CNT_W > mstk_pkg::POS_W) ? CNT_W : mstk_pkg::POS_W;

	mstk_pkg::op_t         op_q;
	logic [KEY_BITS-1:0]   mat_q;
	logic [KEY_BITS-1:0]   mesh_q;
	logic [TAG_BITS-1:0]   tag_q;
	logic [CMP_W-1:0]      pos_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  full;
	logic                  out_of_range;

	logic [AW-1:0]         lo_stk [SD];
	logic [AW-1:0]         hi_stk [SD];
	mstk_pkg::stage_t      stage_stk [SD];
	logic [SPC_W-1:0]      sp_q;
	logic [SPW-1:0]        top_idx;
	logic [SPW-1:0]        push_idx;
	logic [AW-1:0]         top_lo;
	logic [AW-1:0]         top_hi;
	logic [AW-1:0]         mid;

	logic [AW-1:0]         k_q;
	logic [AW:0]           i_q;
	logic [AW:0]           j_q;
	logic                  i_done;
	logic                  j_done;
	logic                  take_left;

	logic                  store_wr_en;
	logic [AW-1:0]         store_wr_addr;
	logic [RW-1:0]         store_wr_data;
	logic [RW-1:0]         store_rd_a;
	logic [RW-1:0]         store_rd_b;
	logic [RW-1:0]         scr_rd_a;
	logic [RW-1:0]         scr_rd_b;
	logic [RW-1:0]         merged;

	mstk_pkg::rsp_t        rsp_d;
	mstk_pkg::rsp_t        out_q;

	assign full         = (count_q == CNT_W'(DEPTH));
	assign out_of_range = (pos_q >= CMP_W'(count_q));

	always_comb begin
		count_d = count_q;
		if (ctl.clear) begin
			count_d = '0;
		end else if (ctl.push && !full) begin
			count_d = count_q + 1'b1;
		end
	end

	assign top_idx  = SPW'(sp_q - 1'b1);
	assign push_idx = SPW'(sp_q);
	assign top_lo   = lo_stk[top_idx];
	assign top_hi   = hi_stk[top_idx];
	assign mid      = top_lo + AW'((top_hi - top_lo) >> 1);

	// On equal keys the right-half record wins.
	assign i_done    = (i_q > (AW + 1)'(mid));
	assign j_done    = (j_q > (AW + 1)'(top_hi));
	assign take_left = j_done || (!i_done && (scr_rd_a[RW-1 -: KW] < scr_rd_b[RW-1 -: KW]));
	assign merged    = take_left ? scr_rd_a : scr_rd_b;

	assign store_wr_en   = (ctl.push && !full) || ctl.merge_wr;
	assign store_wr_addr = ctl.merge_wr ? k_q : count_q[AW-1:0];
	assign store_wr_data = ctl.merge_wr ? merged : {mat_q, mesh_q, tag_q};

	mstk_ram #(
		.WIDTH (RW),
		.DEPTH (DEPTH)
	) u_store (
		.clk       (clk),
		.wr_en     (store_wr_en),
		.wr_addr   (store_wr_addr),
		.wr_data   (store_wr_data),
		.rd_addr_a (k_q),
		.rd_data_a (store_rd_a),
		.rd_addr_b (pos_q[AW-1:0]),
		.rd_data_b (store_rd_b)
	);

	mstk_ram #(
		.WIDTH (RW),
		.DEPTH (DEPTH)
	) u_scratch (
		.clk       (clk),
		.wr_en     (ctl.copy_wr),
		.wr_addr   (k_q),
		.wr_data   (store_rd_a),
		.rd_addr_a (i_q[AW-1:0]),
		.rd_data_a (scr_rd_a),
		.rd_addr_b (j_q[AW-1:0]),
		.rd_data_b (scr_rd_b)
	);

	always_comb begin
		rsp_d            = '0;
		rsp_d.item_count = mstk_pkg::CNT_OUT_W'(count_d);
		unique case (op_q)
			mstk_pkg::OP_PUSH: begin
				if (full) begin
					rsp_d.status = mstk_pkg::ST_FULL;
				end
			end
			mstk_pkg::OP_READ: begin
				if (out_of_range) begin
					rsp_d.status = mstk_pkg::ST_RANGE;
				end else begin
					rsp_d.out_material_key = mstk_pkg::KEY_W'(store_rd_b[RW-1 -: KEY_BITS]);
					rsp_d.out_mesh_key     =
						mstk_pkg::KEY_W'(store_rd_b[TAG_BITS+KEY_BITS-1 -: KEY_BITS]);
					rsp_d.out_tag          = mstk_pkg::TAG_W'(store_rd_b[TAG_BITS-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sp_q    <= '0;
		end else begin
			count_q <= count_d;
			if (ctl.frame_init) begin
				sp_q <= SPC_W'(1);
			end else if (ctl.split_left || ctl.split_right) begin
				sp_q <= sp_q + 1'b1;
			end else if (ctl.pop) begin
				sp_q <= sp_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q   <= mstk_pkg::op_t'(in_word.op);
			mat_q  <= KEY_BITS'(in_word.material_key);
			mesh_q <= KEY_BITS'(in_word.mesh_key);
			tag_q  <= TAG_BITS'(in_word.item_tag);
			pos_q  <= CMP_W'(in_word.position);
		end

		if (ctl.frame_init) begin
			lo_stk[0]    <= '0;
			hi_stk[0]    <= AW'(count_q - 1'b1);
			stage_stk[0] <= mstk_pkg::FR_NEW;
		end else if (ctl.split_left) begin
			stage_stk[top_idx]  <= mstk_pkg::FR_LEFT;
			lo_stk[push_idx]    <= top_lo;
			hi_stk[push_idx]    <= mid;
			stage_stk[push_idx] <= mstk_pkg::FR_NEW;
		end else if (ctl.split_right) begin
			stage_stk[top_idx]  <= mstk_pkg::FR_RIGHT;
			lo_stk[push_idx]    <= mid + 1'b1;
			hi_stk[push_idx]    <= top_hi;
			stage_stk[push_idx] <= mstk_pkg::FR_NEW;
		end

		priority if (ctl.merge_init) begin
			i_q <= (AW + 1)'(top_lo);
			j_q <= (AW + 1)'(mid) + 1'b1;
			k_q <= top_lo;
		end else if (ctl.copy_init) begin
			k_q <= top_lo;
		end else if (ctl.copy_wr) begin
			k_q <= k_q + 1'b1;
		end else if (ctl.merge_wr) begin
			if (take_left) begin
				i_q <= i_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
			k_q <= k_q + 1'b1;
		end else begin
			k_q <= k_q;
		end

		if (ctl.rsp_load) begin
			out_q <= rsp_d;
		end
	end

	assign out_word = out_q;

	assign stat.op        = op_q;
	assign stat.trivial   = (count_q <= CNT_W'(1));
	assign stat.stk_empty = (sp_q == '0);
	assign stat.stage     = stage_stk[top_idx];
	assign stat.leaf      = (top_lo >= top_hi);
	assign stat.last      = (k_q == top_hi);

endmodule

>>> sv/mstk_ctrl.sv
module mstk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output mstk_pkg::dp_cmd_t  ctl,
	input  mstk_pkg::dp_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_FRAME,
		S_COPY_RD,
		S_COPY_WR,
		S_MERGE_RD,
		S_MERGE_WR
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   valid_q;

	assign in_ready  = (state_q == S_IDLE) && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.op)
					mstk_pkg::OP_PUSH: begin
						ctl.push     = 1'b1;
						ctl.rsp_load = 1'b1;
						state_d      = S_IDLE;
					end
					mstk_pkg::OP_CLEAR: begin
						ctl.clear    = 1'b1;
						ctl.rsp_load = 1'b1;
						state_d      = S_IDLE;
					end
					mstk_pkg::OP_READ: begin
						state_d = S_READ;
					end
					mstk_pkg::OP_SORT: begin
						if (stat.trivial) begin
							ctl.rsp_load = 1'b1;
							state_d      = S_IDLE;
						end else begin
							ctl.frame_init = 1'b1;
							state_d        = S_FRAME;
						end
					end
				endcase
			end
			S_READ: begin
				ctl.rsp_load = 1'b1;
				state_d      = S_IDLE;
			end
			S_FRAME: begin
				if (stat.stk_empty) begin
					ctl.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end else begin
					unique case (stat.stage)
						mstk_pkg::FR_NEW: begin
							if (stat.leaf) begin
								ctl.pop = 1'b1;
							end else begin
								ctl.split_left = 1'b1;
							end
						end
						mstk_pkg::FR_LEFT: begin
							ctl.split_right = 1'b1;
						end
						mstk_pkg::FR_RIGHT: begin
							ctl.copy_init = 1'b1;
							state_d       = S_COPY_RD;
						end
						default: begin
							ctl.pop = 1'b1;
						end
					endcase
				end
			end
			S_COPY_RD: begin
				state_d = S_COPY_WR;
			end
			S_COPY_WR: begin
				ctl.copy_wr = 1'b1;
				if (stat.last) begin
					ctl.merge_init = 1'b1;
					state_d        = S_MERGE_RD;
				end else begin
					state_d = S_COPY_RD;
				end
			end
			S_MERGE_RD: begin
				state_d = S_MERGE_WR;
			end
			S_MERGE_WR: begin
				ctl.merge_wr = 1'b1;
				if (stat.last) begin
					ctl.pop = 1'b1;
					state_d = S_FRAME;
				end else begin
					state_d = S_MERGE_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.rsp_load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/merge_sort_two_key_records.sv
// Channel  Direction  Word carries
// cmd      in         op, material_key, mesh_key, item_tag, position
// rsp      out        out_material_key, out_mesh_key, out_tag, item_count, status
//
// Push and clear load their result in the execute state; read passes through a read state first.
// Sorting moves every record into the scratch memory and back at each merge level, each
// move a read state and a write state through the registered-read record memories, and
// each range on the frame stack also passes through the frame state to be split or popped.
// Reset clears the record count, the frame stack pointer and the result valid flag; the
// memories are not cleared. A result waits in the output register, and the next command is
// taken in the cycle its result is taken or any cycle after.
`include "merge_sort_two_key_records_macros.svh"

module merge_sort_two_key_records #(
	parameter int unsigned DEPTH    = mstk_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS = mstk_pkg::KEY_BITS_DEF,
	parameter int unsigned TAG_BITS = mstk_pkg::TAG_BITS_DEF
) (
	input logic  clk,
	input logic  arst_n,
	mstk_chan_if.sink   cmd,
	mstk_chan_if.source rsp
);

	mstk_pkg::dp_cmd_t  dp_ctl;
	mstk_pkg::dp_stat_t dp_stat;
	logic               cmd_fire;
	logic               range_rsp;
	logic               rsp_data_zero;

	mstk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (dp_ctl),
		.stat      (dp_stat)
	);

	mstk_dp #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS),
		.TAG_BITS (TAG_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (cmd.payload),
		.out_word (rsp.payload),
		.ctl      (dp_ctl),
		.stat     (dp_stat)
	);

	assign cmd_fire      = cmd.valid && cmd.ready;
	assign range_rsp     = rsp.valid && (rsp.payload.status == mstk_pkg::ST_RANGE);
	assign rsp_data_zero = (rsp.payload.out_material_key == '0) &&
		(rsp.payload.out_mesh_key == '0) && (rsp.payload.out_tag == '0);

	`MSTK_ASSERT_NEXT(a_busy_after_accept, cmd_fire, !cmd.ready, "command accepted while busy")
	`MSTK_ASSERT_SAME(a_pop_nonempty, dp_ctl.pop, !dp_stat.stk_empty, "empty frame stack popped")
	`MSTK_ASSERT_SAME(a_rsp_free, dp_ctl.rsp_load, !rsp.valid, "result overwritten before taken")
	`MSTK_ASSERT_SAME(a_range_zero, range_rsp, rsp_data_zero, "out of range read carries data")

endmodule
